FILE: rtl/qts_pkg.sv
// Shared types and constants of the quoted token splitter.
`timescale 1ns / 1ps

package qts_pkg;

  localparam logic [7:0] QUOTE_CHAR = 8'h22;
  localparam logic [7:0] SLASH_CHAR = 8'h2F;
  localparam logic [7:0] SPACE_CHAR = 8'h20;
  localparam logic [6:0] DELIM_RESET = 7'h20;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_EOL  = 1'b1;

  localparam logic [1:0] KIND_BYTE    = 2'd0;
  localparam logic [1:0] KIND_END     = 2'd1;
  localparam logic [1:0] KIND_ABANDON = 2'd2;
  localparam logic [1:0] KIND_LINE    = 2'd3;

  localparam int unsigned MaxResults = 3;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
  } result_t;

  // All results caused by one input word, in order, with their number.
  typedef struct packed {
    logic [1:0]                  count;
    result_t [MaxResults-1:0]    res;
  } bundle_t;

endpackage

FILE: rtl/qts_scan.sv
// Scan state of the splitter and the per-word result generation.
`timescale 1ns / 1ps

module qts_scan import qts_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic       operation_i,
  input  logic [7:0] byte_in_i,
  input  logic [6:0] delim_i,
  output bundle_t    bundle_o
);

  typedef enum logic [1:0] {
    MODE_READ,
    MODE_QUOTE,
    MODE_SKIP,
    MODE_COMMENT
  } mode_e;

  typedef struct packed {
    mode_e   mode;
    logic    tok;
    logic    emit;
    result_t res;
  } step_t;

  function automatic logic is_delim(logic [7:0] c, logic [6:0] d);
    return !c[7] && ((c[6:0] == d) || (c >= 8'd9 && c <= 8'd13) || (c == SPACE_CHAR));
  endfunction

  // Read-mode handling of one byte once the slash pair test is done.
  function automatic step_t read_plain(mode_e m, logic t, logic [7:0] c, logic [6:0] d);
    step_t s;
    s.mode = m;
    s.tok  = t;
    s.emit = 1'b0;
    s.res  = '0;
    if (is_delim(c, d)) begin
      s.emit     = t;
      s.res.kind = KIND_END;
      s.tok      = 1'b0;
      s.mode     = MODE_SKIP;
    end else if (c == QUOTE_CHAR) begin
      s.emit     = t;
      s.res.kind = KIND_ABANDON;
      s.tok      = 1'b1;
      s.mode     = MODE_QUOTE;
    end else begin
      s.emit     = 1'b1;
      s.res.kind = KIND_BYTE;
      s.res.data = c;
      s.tok      = 1'b1;
    end
    return s;
  endfunction

  mode_e   mode_q, mode_d;
  logic    slash_q, slash_d;
  logic    tok_q, tok_d;
  logic    nonempty_q, nonempty_d;
  bundle_t bundle;
  step_t   rp_slash, rp_byte;
  logic    done;

  always_comb begin
    mode_d     = mode_q;
    slash_d    = slash_q;
    tok_d      = tok_q;
    nonempty_d = nonempty_q;
    bundle     = '0;
    rp_slash   = '0;
    rp_byte    = '0;
    done       = 1'b0;
    if (operation_i == OP_BYTE) begin
      nonempty_d = 1'b1;
      if (mode_q == MODE_COMMENT) begin
        done = 1'b1;
      end else if (mode_q == MODE_QUOTE) begin
        done = 1'b1;
        if (byte_in_i == QUOTE_CHAR) begin
          bundle.res[bundle.count] = '{kind: KIND_END, data: 8'd0};
          bundle.count             = bundle.count + 2'd1;
          tok_d                    = 1'b0;
          mode_d                   = MODE_SKIP;
        end else begin
          bundle.res[bundle.count] = '{kind: KIND_BYTE, data: byte_in_i};
          bundle.count             = bundle.count + 2'd1;
        end
      end else if (slash_q) begin
        slash_d = 1'b0;
        if (byte_in_i == SLASH_CHAR) begin
          // Double slash: the rest of the line is a comment.
          done = 1'b1;
          if (tok_q) begin
            bundle.res[bundle.count] = '{kind: KIND_ABANDON, data: 8'd0};
            bundle.count             = bundle.count + 2'd1;
          end
          tok_d  = 1'b0;
          mode_d = MODE_COMMENT;
        end else begin
          rp_slash = read_plain(mode_d, tok_d, SLASH_CHAR, delim_i);
          mode_d   = rp_slash.mode;
          tok_d    = rp_slash.tok;
          if (rp_slash.emit) begin
            bundle.res[bundle.count] = rp_slash.res;
            bundle.count             = bundle.count + 2'd1;
          end
        end
      end
      if (!done && !(mode_d == MODE_SKIP && is_delim(byte_in_i, delim_i))) begin
        mode_d = MODE_READ;
        if (byte_in_i == SLASH_CHAR) begin
          slash_d = 1'b1;
        end else begin
          rp_byte = read_plain(mode_d, tok_d, byte_in_i, delim_i);
          mode_d  = rp_byte.mode;
          tok_d   = rp_byte.tok;
          if (rp_byte.emit) begin
            bundle.res[bundle.count] = rp_byte.res;
            bundle.count             = bundle.count + 2'd1;
          end
        end
      end
    end else begin
      // End of line: a held slash counts as an ordinary byte first.
      if (mode_q != MODE_COMMENT && slash_q) begin
        rp_slash = read_plain(mode_d, tok_d, SLASH_CHAR, delim_i);
        mode_d   = rp_slash.mode;
        tok_d    = rp_slash.tok;
        if (rp_slash.emit) begin
          bundle.res[bundle.count] = rp_slash.res;
          bundle.count             = bundle.count + 2'd1;
        end
      end
      if (mode_d != MODE_SKIP && mode_d != MODE_COMMENT && nonempty_q && tok_d) begin
        bundle.res[bundle.count] = '{kind: KIND_END, data: 8'd0};
        bundle.count             = bundle.count + 2'd1;
      end
      bundle.res[bundle.count] = '{kind: KIND_LINE, data: 8'd0};
      bundle.count             = bundle.count + 2'd1;
      mode_d     = MODE_READ;
      slash_d    = 1'b0;
      tok_d      = 1'b0;
      nonempty_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_READ;
      slash_q    <= 1'b0;
      tok_q      <= 1'b0;
      nonempty_q <= 1'b0;
    end else if (accept_i) begin
      mode_q     <= mode_d;
      slash_q    <= slash_d;
      tok_q      <= tok_d;
      nonempty_q <= nonempty_d;
    end
  end

  assign bundle_o = bundle;

endmodule

FILE: rtl/qts_rbuf.sv
// Two-entry queue of result bundles, unpacked one result per output word.
`timescale 1ns / 1ps

module qts_rbuf import qts_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  bundle_t    bundle_i,
  output logic       space_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] kind_o,
  output logic [7:0] byte_out_o,
  output logic       last_o
);

  bundle_t    ent_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic [1:0] sub_q;
  bundle_t    head;
  result_t    cur;
  logic       fire, pop;

  assign head        = ent_q[rd_q];
  assign cur         = head.res[sub_q];
  assign out_valid_o = (cnt_q != 2'd0);
  assign kind_o      = cur.kind;
  assign byte_out_o  = cur.data;
  assign last_o      = (sub_q == head.count - 2'd1);
  assign space_o     = (cnt_q != 2'd2);
  assign fire        = out_valid_o && out_ready_i;
  assign pop         = fire && last_o;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_q] <= bundle_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
      sub_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q  <= ~rd_q;
        sub_q <= 2'd0;
      end else if (fire) begin
        sub_q <= sub_q + 2'd1;
      end
      if (push_i && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

FILE: rtl/quoted_token_splitter_unit.sv
// Results of an accepted word are registered in the queue and offered after earlier ones.
// Throughput: one input word per cycle while each word yields at most one result and the
// output is ready; a word with several results holds the one-result-per-cycle output port.
// Two result bundles are queued, so input stalls only once both are waiting.
// Reset clears the scan state, the queue and sets the delimiter register to a space.
`timescale 1ns / 1ps

module quoted_token_splitter_unit import qts_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [6:0] delimiter_char_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       operation_i,
  input  logic [7:0] byte_in_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] kind_o,
  output logic [7:0] byte_out_o,
  output logic       last_o
);

  logic [6:0] delim_q;
  logic       accept;
  logic       space;
  bundle_t    bundle;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = space;
  assign accept      = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_q <= DELIM_RESET;
    end else if (cfg_valid_i) begin
      delim_q <= delimiter_char_i;
    end
  end

  qts_scan u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .operation_i(operation_i),
    .byte_in_i  (byte_in_i),
    .delim_i    (delim_q),
    .bundle_o   (bundle)
  );

  qts_rbuf u_rbuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (accept && (bundle.count != 2'd0)),
    .bundle_i   (bundle),
    .space_o    (space),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .kind_o     (kind_o),
    .byte_out_o (byte_out_o),
    .last_o     (last_o)
  );

`ifndef SYNTH
  // An end-of-line word always yields a result, so the output must have a word next cycle.
  a_eol_gives_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && operation_i == OP_EOL) |=> out_valid_o)
    else $error("end of line produced no output word");

  // Line done is always the final result of its input word.
  a_line_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == KIND_LINE) |-> last_o)
    else $error("line done word not marked last");

  // Marker words carry a zero byte.
  a_marker_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o != KIND_BYTE) |-> (byte_out_o == 8'd0))
    else $error("marker word with nonzero byte");
`endif

endmodule
